// File: rtl/s20_pkg.sv
package s20_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int RoundCntW = $clog2(2 * DOUBLE_ROUNDS + 1);

  localparam logic [31:0] ConstW0 = 32'h61707865;
  localparam logic [31:0] ConstW5Wide = 32'h3320646e;
  localparam logic [31:0] ConstW5Narrow = 32'h3120646e;
  localparam logic [31:0] ConstW10Wide = 32'h79622d32;
  localparam logic [31:0] ConstW10Narrow = 32'h79622d36;
  localparam logic [31:0] ConstW15 = 32'h6b206574;

  localparam logic [2:0] RegKey01 = 3'd0;
  localparam logic [2:0] RegKey23 = 3'd1;
  localparam logic [2:0] RegKey45 = 3'd2;
  localparam logic [2:0] RegKey67 = 3'd3;
  localparam logic [2:0] RegNonce = 3'd4;
  localparam logic [2:0] RegKeyLen = 3'd5;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] block_t;

  typedef struct packed {
    logic load;
    logic round;
    logic col;
    logic finish;
    logic clear_ctr;
  } s20_cmd_t;

  function automatic word_t rotl(word_t v, int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] qr(word_t a, word_t b, word_t c, word_t d);
    word_t b1, c1, d1, a1;
    b1 = b ^ rotl(a + d, 7);
    c1 = c ^ rotl(b1 + a, 9);
    d1 = d ^ rotl(c1 + b1, 13);
    a1 = a ^ rotl(d1 + c1, 18);
    qr = {a1, b1, c1, d1};
  endfunction

endpackage

// File: rtl/s20_datapath.sv
module s20_datapath (
  input  logic                clk,
  input  s20_pkg::s20_cmd_t   cmd,
  input  logic [63:0]         key01,
  input  logic [63:0]         key23,
  input  logic [63:0]         key45,
  input  logic [63:0]         key67,
  input  logic [63:0]         nonce_w,
  input  logic                wide,
  input  logic                rst,
  input  logic [5:0]          pos,
  output logic [7:0]          ks_byte
);
  import s20_pkg::*;

  block_t init;
  block_t w;
  block_t ks;
  block_t rnd;
  logic [63:0] ctr;
  logic [63:0] hi_a;
  logic [63:0] hi_b;
  logic [127:0] q0, q1, q2, q3;
  word_t sel;

  assign hi_a = wide ? key45 : key01;
  assign hi_b = wide ? key67 : key23;

  always_comb begin
    if (cmd.col) begin
      q0 = qr(w[0], w[4], w[8], w[12]);
      q1 = qr(w[5], w[9], w[13], w[1]);
      q2 = qr(w[10], w[14], w[2], w[6]);
      q3 = qr(w[15], w[3], w[7], w[11]);
      rnd[0] = q0[127:96]; rnd[4] = q0[95:64]; rnd[8] = q0[63:32]; rnd[12] = q0[31:0];
      rnd[5] = q1[127:96]; rnd[9] = q1[95:64]; rnd[13] = q1[63:32]; rnd[1] = q1[31:0];
      rnd[10] = q2[127:96]; rnd[14] = q2[95:64]; rnd[2] = q2[63:32]; rnd[6] = q2[31:0];
      rnd[15] = q3[127:96]; rnd[3] = q3[95:64]; rnd[7] = q3[63:32]; rnd[11] = q3[31:0];
    end else begin
      q0 = qr(w[0], w[1], w[2], w[3]);
      q1 = qr(w[5], w[6], w[7], w[4]);
      q2 = qr(w[10], w[11], w[8], w[9]);
      q3 = qr(w[15], w[12], w[13], w[14]);
      rnd[0] = q0[127:96]; rnd[1] = q0[95:64]; rnd[2] = q0[63:32]; rnd[3] = q0[31:0];
      rnd[5] = q1[127:96]; rnd[6] = q1[95:64]; rnd[7] = q1[63:32]; rnd[4] = q1[31:0];
      rnd[10] = q2[127:96]; rnd[11] = q2[95:64]; rnd[8] = q2[63:32]; rnd[9] = q2[31:0];
      rnd[15] = q3[127:96]; rnd[12] = q3[95:64]; rnd[13] = q3[63:32]; rnd[14] = q3[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr <= '0;
    end else if (cmd.clear_ctr) begin
      ctr <= '0;
    end else if (cmd.finish) begin
      ctr <= ctr + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      init[0] <= ConstW0;
      init[5] <= wide ? ConstW5Wide : ConstW5Narrow;
      init[10] <= wide ? ConstW10Wide : ConstW10Narrow;
      init[15] <= ConstW15;
      init[1] <= key01[31:0];
      init[2] <= key01[63:32];
      init[3] <= key23[31:0];
      init[4] <= key23[63:32];
      init[11] <= hi_a[31:0];
      init[12] <= hi_a[63:32];
      init[13] <= hi_b[31:0];
      init[14] <= hi_b[63:32];
      init[6] <= nonce_w[31:0];
      init[7] <= nonce_w[63:32];
      init[8] <= ctr[31:0];
      init[9] <= ctr[63:32];
      w[0] <= ConstW0;
      w[5] <= wide ? ConstW5Wide : ConstW5Narrow;
      w[10] <= wide ? ConstW10Wide : ConstW10Narrow;
      w[15] <= ConstW15;
      w[1] <= key01[31:0];
      w[2] <= key01[63:32];
      w[3] <= key23[31:0];
      w[4] <= key23[63:32];
      w[11] <= hi_a[31:0];
      w[12] <= hi_a[63:32];
      w[13] <= hi_b[31:0];
      w[14] <= hi_b[63:32];
      w[6] <= nonce_w[31:0];
      w[7] <= nonce_w[63:32];
      w[8] <= ctr[31:0];
      w[9] <= ctr[63:32];
    end else if (cmd.round) begin
      w <= rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      for (int i = 0; i < 16; i++) begin
        ks[i] <= w[i] + init[i];
      end
    end
  end

  assign sel = ks[pos[5:2]];
  assign ks_byte = sel[8 * pos[1:0] +: 8];

endmodule

// File: rtl/s20_ctrl.sv
module s20_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_restart,
  input  logic               out_stall,
  output logic               in_stall,
  output logic               out_valid,
  output logic               take,
  output logic [5:0]         pos,
  output s20_pkg::s20_cmd_t  cmd
);
  import s20_pkg::*;

  typedef enum logic [1:0] {IDLE, LOAD, ROUND, FIN} state_t;

  state_t state;
  logic empty;
  logic [RoundCntW-1:0] rcnt;
  logic need;
  logic pend_restart;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign need = in_valid && ((in_restart && !pend_restart) || empty);
  assign in_stall = !(state == IDLE && out_free && !need);
  assign take = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.load = (state == LOAD);
    cmd.round = (state == ROUND);
    cmd.col = !rcnt[0];
    cmd.finish = (state == FIN);
    cmd.clear_ctr = (state == IDLE) && in_valid && in_restart && !pend_restart;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      empty <= 1'b1;
      pos <= '0;
      rcnt <= '0;
      out_valid <= 1'b0;
      pend_restart <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (take) begin
            pos <= pos + 6'd1;
            pend_restart <= 1'b0;
            if (pos == 6'd63) begin
              empty <= 1'b1;
            end
          end else if (need) begin
            pend_restart <= 1'b1;
            state <= LOAD;
          end
        end
        LOAD: begin
          rcnt <= '0;
          state <= ROUND;
        end
        ROUND: begin
          rcnt <= rcnt + 1'b1;
          if (rcnt == RoundCntW'(2 * DOUBLE_ROUNDS - 1)) begin
            state <= FIN;
          end
        end
        FIN: begin
          empty <= 1'b0;
          pos <= '0;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: rtl/salsa20_stream_cipher.sv
// Results are registered: each appears in the cycle after its item is accepted.
// An item that needs a new block (or asks for restart) is stalled while the shared round
// unit steps through the LOAD, ROUND and FIN states, and is taken once the block is built.
// Throughput: one item per cycle while the output does not stall, with a block build every 64 items.
// Reset (synchronous, rst high): counter zero, buffer empty, 256-bit key mode.
module salsa20_stream_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  cipher_byte,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import s20_pkg::*;

  s20_cmd_t cmd;
  logic [63:0] key01, key23, key45, key67, nonce_r;
  logic wide;
  logic take;
  logic [5:0] pos;
  logic [7:0] ks_byte;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      key01 <= '0; key23 <= '0; key45 <= '0; key67 <= '0; nonce_r <= '0;
      wide <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      case (ridx)
        RegKey01: key01 <= pwdata;
        RegKey23: key23 <= pwdata;
        RegKey45: key45 <= pwdata;
        RegKey67: key67 <= pwdata;
        RegNonce: nonce_r <= pwdata;
        RegKeyLen: wide <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      RegKey01: prdata = key01;
      RegKey23: prdata = key23;
      RegKey45: prdata = key45;
      RegKey67: prdata = key67;
      RegNonce: prdata = nonce_r;
      RegKeyLen: prdata = {63'd0, wide};
      default: prdata = '0;
    endcase
  end

  s20_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_restart(restart), .out_stall, .in_stall,
    .out_valid, .take, .pos, .cmd
  );

  s20_datapath u_dp (
    .clk, .cmd, .key01, .key23, .key45, .key67, .nonce_w(nonce_r), .wide,
    .rst, .pos, .ks_byte
  );

  always_ff @(posedge clk) begin
    if (take) begin
      cipher_byte <= data_byte ^ ks_byte;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cipher_byte))
    else $error("result changed while stalled");
  a_take: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("accepted item gave no result");
  a_build: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !take)
    else $error("item taken during block build");

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import s20_pkg::*;

  class cipher_board;
    bit [63:0] key01, key23, key45, key67, nonce_r;
    bit wide;
    bit [63:0] counter;
    int unsigned pos;
    word_t ks [16];
    bit [7:0] pending [$];
    int errors;

    function void reset_state();
      key01 = 0; key23 = 0; key45 = 0; key67 = 0; nonce_r = 0;
      wide = 1; counter = 0; pos = 64; errors = 0;
      pending.delete();
    endfunction

    function void write_reg(logic [2:0] idx, bit [63:0] v);
      case (idx)
        RegKey01: key01 = v;
        RegKey23: key23 = v;
        RegKey45: key45 = v;
        RegKey67: key67 = v;
        RegNonce: nonce_r = v;
        RegKeyLen: wide = v[0];
        default: ;
      endcase
    endfunction

    function word_t rl(word_t v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void mix(ref word_t w[16], input int a, int b, int c, int d);
      w[b] ^= rl(w[a] + w[d], 7);
      w[c] ^= rl(w[b] + w[a], 9);
      w[d] ^= rl(w[c] + w[b], 13);
      w[a] ^= rl(w[d] + w[c], 18);
    endfunction

    function void build();
      word_t init [16];
      word_t w [16];
      bit [63:0] ha, hb;
      ha = wide ? key45 : key01;
      hb = wide ? key67 : key23;
      init[0] = 32'h61707865;
      init[5] = wide ? 32'h3320646e : 32'h3120646e;
      init[10] = wide ? 32'h79622d32 : 32'h79622d36;
      init[15] = 32'h6b206574;
      init[1] = key01[31:0]; init[2] = key01[63:32];
      init[3] = key23[31:0]; init[4] = key23[63:32];
      init[11] = ha[31:0]; init[12] = ha[63:32];
      init[13] = hb[31:0]; init[14] = hb[63:32];
      init[6] = nonce_r[31:0]; init[7] = nonce_r[63:32];
      init[8] = counter[31:0]; init[9] = counter[63:32];
      w = init;
      for (int r = 0; r < 10; r++) begin
        mix(w, 0, 4, 8, 12); mix(w, 5, 9, 13, 1);
        mix(w, 10, 14, 2, 6); mix(w, 15, 3, 7, 11);
        mix(w, 0, 1, 2, 3); mix(w, 5, 6, 7, 4);
        mix(w, 10, 11, 8, 9); mix(w, 15, 12, 13, 14);
      end
      for (int i = 0; i < 16; i++) ks[i] = w[i] + init[i];
      pos = 0;
      counter++;
    endfunction

    function void note_input(bit [7:0] d, bit rs);
      word_t wv;
      if (rs) begin
        counter = 0;
        pos = 64;
      end
      if (pos >= 64) build();
      wv = ks[pos >> 2];
      pending.push_back(d ^ wv[(pos & 3) * 8 +: 8]);
      pos++;
    endfunction

    function void check_result(bit [7:0] got);
      bit [7:0] exp_b;
      if (pending.size() == 0) begin
        $error("cipher_byte: no item expected, actual %h", got);
        errors++;
        return;
      end
      exp_b = pending.pop_front();
      if (exp_b !== got) begin
        $error("cipher_byte: expected %h, actual %h", exp_b, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, restart = 0, out_stall = 0;
  logic [7:0] data_byte = 0;
  logic out_valid, in_stall, pready;
  logic [7:0] cipher_byte;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [5:0] paddr = 0;
  logic [63:0] pwdata = 0, prdata;
  cipher_board board;

  salsa20_stream_cipher uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(cipher_byte);
  end

  initial begin
    int unsigned n;
    @(negedge clk);
    forever begin
      n = $urandom_range(0, 8);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic write_reg(logic [2:0] idx, bit [63:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.write_reg(idx, v);
  endtask

  task automatic send_byte(bit [7:0] d, bit rs, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1; data_byte <= d; restart <= rs;
    do @(posedge clk); while (in_stall);
    board.note_input(d, rs);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic random_keys(bit w);
    write_reg(RegKey01, {$urandom, $urandom});
    write_reg(RegKey23, {$urandom, $urandom});
    write_reg(RegKey45, {$urandom, $urandom});
    write_reg(RegKey67, {$urandom, $urandom});
    write_reg(RegNonce, {$urandom, $urandom});
    write_reg(RegKeyLen, w);
  endtask

  initial begin
    board = new();
    board.reset_state();
    repeat (6) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send_byte(8'h00, 0, 0);
    send_byte(8'hff, 0, 0);
    send_byte(8'h5a, 1, 0);
    drain();
    write_reg(RegKey01, '1); write_reg(RegKey23, '1);
    write_reg(RegKey45, '1); write_reg(RegKey67, '1);
    write_reg(RegNonce, '1); write_reg(RegKeyLen, 0);
    for (int i = 0; i < 20; i++) send_byte(i[0] ? 8'hff : 8'h00, i == 0, 0);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      random_keys(ph[0]);
      if (ph == 3) write_reg(RegNonce, 0);
      for (int i = 0; i < 130; i++)
        send_byte($urandom_range(0, 255), ($urandom_range(0, 99) == 0),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0);
      drain();
    end
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

// File: files.f
rtl/s20_pkg.sv
rtl/s20_datapath.sv
rtl/s20_ctrl.sv
rtl/salsa20_stream_cipher.sv
bench/tb.sv
